// ----- rtl/tdp_pkg.sv -----
// Shared types and constants for the 2D point transform pipeline.
`timescale 1ns / 1ps

package tdp_pkg;

    localparam int SCALE_WIDTH = 24;
    localparam int SCALE_FRAC = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCALE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COS = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIN = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_Y = 3'd4;

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'h010000;

    typedef enum logic [1:0] {
        ACT_LOCAL_POINT  = 2'd0,
        ACT_LOCAL_VECTOR = 2'd1,
        ACT_GLOBAL_POINT = 2'd2,
        ACT_PASS         = 2'd3
    } t_action;

endpackage

// ----- rtl/tdp_cfg_regs.sv -----
// Configuration register file holding scale, rotation and translation.
`timescale 1ns / 1ps

module tdp_cfg_regs #(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int CFG_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [tdp_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [CFG_WIDTH-1:0]                  i_cfg_data,
    output logic [tdp_pkg::SCALE_WIDTH-1:0]       o_scale,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_cos,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_sin,
    output logic signed [COORD_WIDTH-1:0]         o_off_x,
    output logic signed [COORD_WIDTH-1:0]         o_off_y
);
    import tdp_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;

    logic [SCALE_WIDTH-1:0]       r_scale;
    logic signed [TW-1:0]         r_cos;
    logic signed [TW-1:0]         r_sin;
    logic signed [COORD_WIDTH-1:0] r_off_x;
    logic signed [COORD_WIDTH-1:0] r_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_cos   <= TW'(1) << TRIG_FRAC_BITS;
            r_sin   <= '0;
            r_off_x <= '0;
            r_off_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE:    r_scale <= i_cfg_data[SCALE_WIDTH-1:0];
                CFG_COS:      r_cos   <= i_cfg_data[TW-1:0];
                CFG_SIN:      r_sin   <= i_cfg_data[TW-1:0];
                CFG_OFFSET_X: r_off_x <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_OFFSET_Y: r_off_y <= i_cfg_data[COORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_scale = r_scale;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_off_x = r_off_x;
    assign o_off_y = r_off_y;

endmodule

// ----- rtl/tdp_scale.sv -----
// Scale and translation-removal stages that produce the rotation operands.
`timescale 1ns / 1ps

module tdp_scale #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  tdp_pkg::t_action                  i_action,
    input  logic signed [COORD_WIDTH-1:0]     i_x,
    input  logic signed [COORD_WIDTH-1:0]     i_y,
    input  logic [tdp_pkg::SCALE_WIDTH-1:0]   i_scale,
    input  logic signed [COORD_WIDTH-1:0]     i_off_x,
    input  logic signed [COORD_WIDTH-1:0]     i_off_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output tdp_pkg::t_action                  o_action,
    output logic signed [COORD_WIDTH:0]       o_ax,
    output logic signed [COORD_WIDTH:0]       o_ay,
    output logic                              o_ov
);
    import tdp_pkg::*;

    localparam int AW = COORD_WIDTH + 1;
    localparam int PW = COORD_WIDTH + SCALE_WIDTH + 1;
    localparam int SW = PW - SCALE_FRAC;
    localparam logic [PW-1:0] PwHalf = PW'(1) << (SCALE_FRAC - 1);

    logic                 en1;
    logic                 en2;
    logic                 r1_valid;
    t_action              r1_action;
    logic signed [PW-1:0] r1_px;
    logic signed [PW-1:0] r1_py;
    logic signed [AW-1:0] r1_alt_x;
    logic signed [AW-1:0] r1_alt_y;
    logic signed [PW-1:0] n1_px;
    logic signed [PW-1:0] n1_py;
    logic signed [AW-1:0] n1_alt_x;
    logic signed [AW-1:0] n1_alt_y;

    logic                 r2_valid;
    t_action              r2_action;
    logic signed [AW-1:0] r2_ax;
    logic signed [AW-1:0] r2_ay;
    logic                 r2_ov;
    logic signed [AW-1:0] n2_ax;
    logic signed [AW-1:0] n2_ay;
    logic                 n2_ov;

    logic [PW-1:0]          px_round;
    logic [PW-1:0]          py_round;
    logic [SW-1:0]          sx_full;
    logic [SW-1:0]          sy_full;
    logic                   sat_x;
    logic                   sat_y;
    logic [COORD_WIDTH-1:0] sx;
    logic [COORD_WIDTH-1:0] sy;

    assign en2 = !r2_valid || i_ready;
    assign en1 = !r1_valid || en2;
    assign o_ready = en1;

    always_comb begin
        n1_px = PW'(i_x) * PW'($signed({1'b0, i_scale}));
        n1_py = PW'(i_y) * PW'($signed({1'b0, i_scale}));
        if (i_action == ACT_GLOBAL_POINT) begin
            n1_alt_x = AW'(i_x) - AW'(i_off_x);
            n1_alt_y = AW'(i_y) - AW'(i_off_y);
        end else begin
            n1_alt_x = AW'(i_x);
            n1_alt_y = AW'(i_y);
        end
    end

    always_comb begin
        px_round = r1_px + PwHalf;
        py_round = r1_py + PwHalf;
        sx_full  = px_round[PW-1:SCALE_FRAC];
        sy_full  = py_round[PW-1:SCALE_FRAC];
        sat_x    = !(&sx_full[SW-1:COORD_WIDTH-1]) && (|sx_full[SW-1:COORD_WIDTH-1]);
        sat_y    = !(&sy_full[SW-1:COORD_WIDTH-1]) && (|sy_full[SW-1:COORD_WIDTH-1]);
        sx = sat_x ? {sx_full[SW-1], {(COORD_WIDTH-1){~sx_full[SW-1]}}}
                   : sx_full[COORD_WIDTH-1:0];
        sy = sat_y ? {sy_full[SW-1], {(COORD_WIDTH-1){~sy_full[SW-1]}}}
                   : sy_full[COORD_WIDTH-1:0];
        if (r1_action == ACT_LOCAL_POINT) begin
            n2_ax = AW'($signed(sx));
            n2_ay = AW'($signed(sy));
            n2_ov = sat_x || sat_y;
        end else begin
            n2_ax = r1_alt_x;
            n2_ay = r1_alt_y;
            n2_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_action <= i_action;
            r1_px     <= n1_px;
            r1_py     <= n1_py;
            r1_alt_x  <= n1_alt_x;
            r1_alt_y  <= n1_alt_y;
        end
        if (en2) begin
            r2_action <= r1_action;
            r2_ax     <= n2_ax;
            r2_ay     <= n2_ay;
            r2_ov     <= n2_ov;
        end
    end

    assign o_valid  = r2_valid;
    assign o_action = r2_action;
    assign o_ax     = r2_ax;
    assign o_ay     = r2_ay;
    assign o_ov     = r2_ov;

endmodule

// ----- rtl/tdp_rotate.sv -----
// Rotation stages: four products, then the rounded sums and differences.
`timescale 1ns / 1ps

module tdp_rotate #(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  tdp_pkg::t_action                      i_action,
    input  logic signed [COORD_WIDTH:0]           i_ax,
    input  logic signed [COORD_WIDTH:0]           i_ay,
    input  logic                                  i_ov,
    input  logic signed [TRIG_FRAC_BITS+1:0]      i_cos,
    input  logic signed [TRIG_FRAC_BITS+1:0]      i_sin,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output tdp_pkg::t_action                      o_action,
    output logic signed [COORD_WIDTH+3:0]         o_qx,
    output logic signed [COORD_WIDTH+3:0]         o_qy,
    output logic signed [COORD_WIDTH:0]           o_ax,
    output logic signed [COORD_WIDTH:0]           o_ay,
    output logic                                  o_ov
);
    import tdp_pkg::*;

    localparam int AW = COORD_WIDTH + 1;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int MW = AW + TW;
    localparam int RW = MW + 1;
    localparam int QW = RW - TRIG_FRAC_BITS;
    localparam logic [RW-1:0] RoundHalf = RW'(1) << (TRIG_FRAC_BITS - 1);

    logic                 en3;
    logic                 en4;
    logic                 r3_valid;
    t_action              r3_action;
    logic signed [MW-1:0] r3_xc;
    logic signed [MW-1:0] r3_ys;
    logic signed [MW-1:0] r3_yc;
    logic signed [MW-1:0] r3_xs;
    logic signed [AW-1:0] r3_ax;
    logic signed [AW-1:0] r3_ay;
    logic                 r3_ov;

    logic                 r4_valid;
    t_action              r4_action;
    logic signed [QW-1:0] r4_qx;
    logic signed [QW-1:0] r4_qy;
    logic signed [AW-1:0] r4_ax;
    logic signed [AW-1:0] r4_ay;
    logic                 r4_ov;

    logic [RW-1:0] sum_x;
    logic [RW-1:0] sum_y;
    logic [QW-1:0] n4_qx;
    logic [QW-1:0] n4_qy;

    assign en4 = !r4_valid || i_ready;
    assign en3 = !r3_valid || en4;
    assign o_ready = en3;

    // The inverse rotation flips the sign of the sine terms.
    always_comb begin
        if (r3_action == ACT_GLOBAL_POINT) begin
            sum_x = RW'(r3_xc) + RW'(r3_ys) + RoundHalf;
            sum_y = RW'(r3_yc) - RW'(r3_xs) + RoundHalf;
        end else begin
            sum_x = RW'(r3_xc) - RW'(r3_ys) + RoundHalf;
            sum_y = RW'(r3_yc) + RW'(r3_xs) + RoundHalf;
        end
        n4_qx = sum_x[RW-1:TRIG_FRAC_BITS];
        n4_qy = sum_y[RW-1:TRIG_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en3) begin
                r3_valid <= i_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_action <= i_action;
            r3_xc     <= MW'(i_ax) * MW'(i_cos);
            r3_ys     <= MW'(i_ay) * MW'(i_sin);
            r3_yc     <= MW'(i_ay) * MW'(i_cos);
            r3_xs     <= MW'(i_ax) * MW'(i_sin);
            r3_ax     <= i_ax;
            r3_ay     <= i_ay;
            r3_ov     <= i_ov;
        end
        if (en4) begin
            r4_action <= r3_action;
            r4_qx     <= n4_qx;
            r4_qy     <= n4_qy;
            r4_ax     <= r3_ax;
            r4_ay     <= r3_ay;
            r4_ov     <= r3_ov;
        end
    end

    assign o_valid  = r4_valid;
    assign o_action = r4_action;
    assign o_qx     = r4_qx;
    assign o_qy     = r4_qy;
    assign o_ax     = r4_ax;
    assign o_ay     = r4_ay;
    assign o_ov     = r4_ov;

endmodule

// ----- rtl/tdp_finish.sv -----
// Output stage: translation, final saturation and the result register.
`timescale 1ns / 1ps

module tdp_finish #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  tdp_pkg::t_action                i_action,
    input  logic signed [COORD_WIDTH+3:0]   i_qx,
    input  logic signed [COORD_WIDTH+3:0]   i_qy,
    input  logic signed [COORD_WIDTH:0]     i_ax,
    input  logic signed [COORD_WIDTH:0]     i_ay,
    input  logic                            i_ov,
    input  logic signed [COORD_WIDTH-1:0]   i_off_x,
    input  logic signed [COORD_WIDTH-1:0]   i_off_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [COORD_WIDTH-1:0]          o_x,
    output logic [COORD_WIDTH-1:0]          o_y,
    output logic                            o_ov
);
    import tdp_pkg::*;

    localparam int VW = COORD_WIDTH + 5;

    logic                   en5;
    logic                   r5_valid;
    logic [COORD_WIDTH-1:0] r5_x;
    logic [COORD_WIDTH-1:0] r5_y;
    logic                   r5_ov;

    logic [VW-1:0]          vx;
    logic [VW-1:0]          vy;
    logic                   sat_x;
    logic                   sat_y;
    logic [COORD_WIDTH-1:0] n5_x;
    logic [COORD_WIDTH-1:0] n5_y;

    assign en5 = !r5_valid || i_ready;
    assign o_ready = en5;

    always_comb begin
        case (i_action)
            ACT_LOCAL_POINT: begin
                vx = VW'(i_qx) + VW'(i_off_x);
                vy = VW'(i_qy) + VW'(i_off_y);
            end
            ACT_PASS: begin
                vx = VW'(i_ax);
                vy = VW'(i_ay);
            end
            default: begin
                vx = VW'(i_qx);
                vy = VW'(i_qy);
            end
        endcase
        sat_x = !(&vx[VW-1:COORD_WIDTH-1]) && (|vx[VW-1:COORD_WIDTH-1]);
        sat_y = !(&vy[VW-1:COORD_WIDTH-1]) && (|vy[VW-1:COORD_WIDTH-1]);
        n5_x = sat_x ? {vx[VW-1], {(COORD_WIDTH-1){~vx[VW-1]}}} : vx[COORD_WIDTH-1:0];
        n5_y = sat_y ? {vy[VW-1], {(COORD_WIDTH-1){~vy[VW-1]}}} : vy[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en5) begin
            r5_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_x  <= n5_x;
            r5_y  <= n5_y;
            r5_ov <= i_ov || sat_x || sat_y;
        end
    end

    assign o_valid = r5_valid;
    assign o_x     = r5_x;
    assign o_y     = r5_y;
    assign o_ov    = r5_ov;

endmodule

// ----- rtl/transform_2d_point.sv -----
// Top level of the 2D similarity transform pipeline.
// The input channel takes one action code and one Q16.16 coordinate pair per
// transfer; the output channel returns the transformed pair and an overflow
// flag that is set when either coordinate, or a scaled intermediate, saturated.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. Configuration writes go through a separate
// valid/ready port that is always ready; they should be made while the
// pipeline holds no items, since items read the registers as they pass.
// Items pass registers r1 to r5 from input transfer to output valid, and one
// item per cycle is sustained while the receiver does not stall. The scaling
// multiplier sits in the first stage and the four rotation multipliers in the
// third; each is followed by a register. A stall from the receiver holds the
// output register and backs up through the stages, each stage still filling
// while it has an empty slot, so no item is lost or repeated. Reset empties
// every stage and loads scale 1.0, cosine 1.0, sine 0 and zero translation.
`timescale 1ns / 1ps

module transform_2d_point #(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC_BITS = 14,
    localparam int CFG_WIDTH = (COORD_WIDTH > tdp_pkg::SCALE_WIDTH) ?
                               COORD_WIDTH : tdp_pkg::SCALE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_action,
    input  logic signed [COORD_WIDTH-1:0]       i_in_x,
    input  logic signed [COORD_WIDTH-1:0]       i_in_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic                                o_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]                i_cfg_data
);
    import tdp_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;

    logic [SCALE_WIDTH-1:0]        scale;
    logic signed [TW-1:0]          cos_v;
    logic signed [TW-1:0]          sin_v;
    logic signed [COORD_WIDTH-1:0] off_x;
    logic signed [COORD_WIDTH-1:0] off_y;

    logic                          sc_ready;
    logic                          sc_valid;
    t_action                       sc_action;
    logic signed [COORD_WIDTH:0]   sc_ax;
    logic signed [COORD_WIDTH:0]   sc_ay;
    logic                          sc_ov;

    logic                          rot_ready;
    logic                          rot_valid;
    t_action                       rot_action;
    logic signed [COORD_WIDTH+3:0] rot_qx;
    logic signed [COORD_WIDTH+3:0] rot_qy;
    logic signed [COORD_WIDTH:0]   rot_ax;
    logic signed [COORD_WIDTH:0]   rot_ay;
    logic                          rot_ov;

    logic                          fin_ready;
    logic [COORD_WIDTH-1:0]        fin_x;
    logic [COORD_WIDTH-1:0]        fin_y;

    assign o_cfg_ready = 1'b1;

    tdp_cfg_regs #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .CFG_WIDTH      (CFG_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_scale     (scale),
        .o_cos       (cos_v),
        .o_sin       (sin_v),
        .o_off_x     (off_x),
        .o_off_y     (off_y)
    );

    tdp_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (sc_ready),
        .i_action (t_action'(i_action)),
        .i_x      (i_in_x),
        .i_y      (i_in_y),
        .i_scale  (scale),
        .i_off_x  (off_x),
        .i_off_y  (off_y),
        .o_valid  (sc_valid),
        .i_ready  (rot_ready),
        .o_action (sc_action),
        .o_ax     (sc_ax),
        .o_ay     (sc_ay),
        .o_ov     (sc_ov)
    );

    tdp_rotate #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sc_valid),
        .o_ready  (rot_ready),
        .i_action (sc_action),
        .i_ax     (sc_ax),
        .i_ay     (sc_ay),
        .i_ov     (sc_ov),
        .i_cos    (cos_v),
        .i_sin    (sin_v),
        .o_valid  (rot_valid),
        .i_ready  (fin_ready),
        .o_action (rot_action),
        .o_qx     (rot_qx),
        .o_qy     (rot_qy),
        .o_ax     (rot_ax),
        .o_ay     (rot_ay),
        .o_ov     (rot_ov)
    );

    tdp_finish #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rot_valid),
        .o_ready  (fin_ready),
        .i_action (rot_action),
        .i_qx     (rot_qx),
        .i_qy     (rot_qy),
        .i_ax     (rot_ax),
        .i_ay     (rot_ay),
        .i_ov     (rot_ov),
        .i_off_x  (off_x),
        .i_off_y  (off_y),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_x      (fin_x),
        .o_y      (fin_y),
        .o_ov     (o_overflow)
    );

    assign o_stall = !sc_ready;
    assign o_out_x = $signed(fin_x);
    assign o_out_y = $signed(fin_y);

endmodule

// ----- bench/tb_transform_2d_point.sv -----
// Self-checking testbench for the 2D point transform pipeline.
`timescale 1ns / 1ps

module tb_transform_2d_point;

    import tdp_pkg::*;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        ov;
    } t_point_result;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    t_action                    in_action = ACT_LOCAL_POINT;
    logic signed [31:0]         in_x = '0;
    logic signed [31:0]         in_y = '0;
    logic                       out_valid;
    logic                       rx_stall = 1'b0;
    logic signed [31:0]         out_x;
    logic signed [31:0]         out_y;
    logic                       out_overflow;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0]                cfg_data = '0;

    logic [SCALE_WIDTH-1:0] cfg_scale = SCALE_RESET;
    longint                 cfg_cos = 16384;
    longint                 cfg_sin = 0;
    longint                 cfg_off_x = 0;
    longint                 cfg_off_y = 0;

    t_point_result pending_points[$];
    t_point_result want_res;
    int            errors = 0;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_hold_req = 0;
    int            rx_hold_left = 0;

    transform_2d_point u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_action    (in_action),
        .i_in_x      (in_x),
        .i_in_y      (in_y),
        .o_valid     (out_valid),
        .i_stall     (rx_stall),
        .o_out_x     (out_x),
        .o_out_y     (out_y),
        .o_overflow  (out_overflow),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_coord(input longint v, inout logic ov);
        if (v > COORD_MAX) begin
            ov = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            ov = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic longint scale_coord(input longint v);
        return (v * longint'({40'd0, cfg_scale}) + 64'sd32768) >>> 16;
    endfunction

    function automatic longint rotate_sum(input longint a, input longint b,
                                          input longint ca, input longint cb);
        return (a * ca + b * cb + 64'sd8192) >>> 14;
    endfunction

    function automatic t_point_result transform_point(input t_action act,
                                                      input logic [31:0] xw,
                                                      input logic [31:0] yw);
        longint        x;
        longint        y;
        longint        sx;
        longint        sy;
        longint        rx;
        longint        ry;
        logic          ov;
        t_point_result r;
        x = $signed(xw);
        y = $signed(yw);
        rx = x;
        ry = y;
        ov = 1'b0;
        case (act)
            ACT_LOCAL_POINT: begin
                sx = clamp_coord(scale_coord(x), ov);
                sy = clamp_coord(scale_coord(y), ov);
                rx = rotate_sum(sx, sy, cfg_cos, -cfg_sin) + cfg_off_x;
                ry = rotate_sum(sy, sx, cfg_cos, cfg_sin) + cfg_off_y;
            end
            ACT_LOCAL_VECTOR: begin
                rx = rotate_sum(x, y, cfg_cos, -cfg_sin);
                ry = rotate_sum(y, x, cfg_cos, cfg_sin);
            end
            ACT_GLOBAL_POINT: begin
                sx = x - cfg_off_x;
                sy = y - cfg_off_y;
                rx = rotate_sum(sx, sy, cfg_cos, cfg_sin);
                ry = rotate_sum(sy, sx, cfg_cos, -cfg_sin);
            end
            default: begin
            end
        endcase
        rx = clamp_coord(rx, ov);
        ry = clamp_coord(ry, ov);
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.ov = ov;
        return r;
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] mag;
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom();
            4, 5: mag = $urandom_range(1 << 20);
            6: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: mag = $urandom_range(1 << 24);
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic t_action pick_action();
        if ($urandom_range(9) == 0) return ACT_PASS;
        return t_action'($urandom_range(2));
    endfunction

    // Starts and ends on a falling edge; valid stays high after the transfer.
    task automatic send_point(input t_action act, input logic [31:0] x,
                              input logic [31:0] y);
        while (tx_idle_on && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_x <= x;
        in_y <= y;
        do @(posedge clk); while (in_stall);
        pending_points.push_back(transform_point(act, x, y));
        @(negedge clk);
    endtask

    task automatic send_random_point();
        send_point(pick_action(), pick_coord(), pick_coord());
    endtask

    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_points.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_config(input logic [31:0] scale_word, input logic [31:0] cos_word,
                              input logic [31:0] sin_word, input logic [31:0] ox,
                              input logic [31:0] oy);
        logic [CFG_INDEX_WIDTH-1:0] idx[5];
        logic [31:0]                word[5];
        idx = '{CFG_SCALE, CFG_COS, CFG_SIN, CFG_OFFSET_X, CFG_OFFSET_Y};
        word = '{scale_word, cos_word, sin_word, ox, oy};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= word[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_SCALE: cfg_scale = word[i][SCALE_WIDTH-1:0];
                CFG_COS: cfg_cos = $signed(word[i][15:0]);
                CFG_SIN: cfg_sin = $signed(word[i][15:0]);
                CFG_OFFSET_X: cfg_off_x = $signed(word[i]);
                CFG_OFFSET_Y: cfg_off_y = $signed(word[i]);
                default: begin
                end
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_random_config();
        logic [31:0] scale_word;
        logic [31:0] trig[2];
        logic [31:0] offs[2];
        int          c;
        case ($urandom_range(2))
            0: scale_word = {8'($urandom_range(255)), 24'h01_0000};
            1: scale_word = $urandom_range(1 << 18);
            default: scale_word = $urandom();
        endcase
        for (int i = 0; i < 2; i++) begin
            c = int'($urandom_range(32768)) - 16384;
            trig[i] = ($urandom_range(4) == 0) ? $urandom() : {16'($urandom()), 16'(c)};
            offs[i] = $urandom_range(1) ? $urandom() : 32'($signed(pick_coord()) >>> 8);
        end
        set_config(scale_word, trig[0], trig[1], offs[0], offs[1]);
    endtask

    always @(negedge clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            rx_stall <= rx_idle_on && ($urandom_range(99) < 36);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !rx_stall) begin
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer x=%h y=%h overflow=%b",
                         $time, out_x, out_y, out_overflow);
            end else begin
                want_res = pending_points.pop_front();
                if (out_x !== want_res.x) begin
                    errors++;
                    $display("%0t: out_x expected %h actual %h", $time, want_res.x, out_x);
                end
                if (out_y !== want_res.y) begin
                    errors++;
                    $display("%0t: out_y expected %h actual %h", $time, want_res.y, out_y);
                end
                if (out_overflow !== want_res.ov) begin
                    errors++;
                    $display("%0t: overflow expected %b actual %b", $time, want_res.ov,
                             out_overflow);
                end
            end
        end
    end

    task automatic test_reset_state();
        send_point(ACT_LOCAL_POINT, 32'h0001_8000, 32'hFFFD_C000);
        send_point(ACT_LOCAL_VECTOR, 32'h0001_8000, 32'hFFFD_C000);
        send_point(ACT_GLOBAL_POINT, 32'h0001_8000, 32'hFFFD_C000);
        send_point(ACT_PASS, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(ACT_LOCAL_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(ACT_LOCAL_POINT, 32'h8000_0000, 32'h8000_0000);
    endtask

    task automatic test_corner_cases();
        // Maximum scale, cosine and sine both at full magnitude, extreme offsets.
        wait_drained(8);
        set_config(32'h00FF_FFFF, 32'hFFFF_C000, 32'h0000_4000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        send_point(ACT_LOCAL_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(ACT_LOCAL_POINT, 32'h8000_0000, 32'h8000_0000);
        send_point(ACT_LOCAL_POINT, 32'h0000_0001, 32'hFFFF_FFFF);
        send_point(ACT_LOCAL_VECTOR, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(ACT_LOCAL_VECTOR, 32'h8000_0000, 32'h8000_0000);
        send_point(ACT_GLOBAL_POINT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(ACT_GLOBAL_POINT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(ACT_PASS, 32'h8000_0000, 32'h7FFF_FFFF);
        // Zero scale and trig words outside the nominal range.
        wait_drained(8);
        set_config(32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h0, 32'h0);
        send_point(ACT_LOCAL_POINT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(ACT_LOCAL_VECTOR, 32'h0000_0001, 32'h0000_0000);
        send_point(ACT_LOCAL_VECTOR, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(ACT_GLOBAL_POINT, 32'hFFFF_FFFF, 32'h0000_0001);
        send_point(ACT_LOCAL_VECTOR, 32'h8000_0000, 32'h7FFF_FFFF);
        // Half scale puts odd values exactly on the rounding midpoint.
        wait_drained(8);
        set_config(32'h0000_8000, 32'h0000_4000, 32'h0, 32'h0, 32'h0);
        send_point(ACT_LOCAL_POINT, 32'h0000_0001, 32'hFFFF_FFFF);
        send_point(ACT_LOCAL_POINT, 32'h0000_0003, 32'hFFFF_FFFD);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            wait_drained(8);
            set_random_config();
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            repeat (100) send_random_point();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_hold();
        wait_drained(8);
        set_random_config();
        tx_idle_on = 1'b0;
        rx_hold_req = 300;
        repeat (80) send_random_point();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (30) send_random_point();
        wait_drained(0);
        repeat (30) send_random_point();
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_corner_cases();
        test_random_settings();
        test_output_hold();
        test_sender_pause();
        wait_drained(12);
        if (errors == 0) begin
            $display("PASS transform_2d_point");
        end else begin
            $display("FAIL transform_2d_point");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL transform_2d_point");
        $finish;
    end

endmodule
